>>> design/pfs_pkg.sv
// Package for the pancake flip sorter: sizes, word types, sequencer states
// and the store request struct. No dependencies.
package pfs_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VALUE_W     = 8;
  localparam int FLIP_W      = 6;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [VALUE_W-1:0] value_t;

  // Input word: one stack element, top first
  typedef struct packed {
    logic [VALUE_W-1:0] diameter;
    logic               end_of_stack;
  } load_word_t;

  // Output word: one flip position, or the terminator
  typedef struct packed {
    logic [FLIP_W-1:0] flip_position;
    logic              last_flip;
  } flip_word_t;

  // Request from the sequencer to the stack store
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    addr_t  raddr_a;
    addr_t  raddr_b;
  } store_req_t;

  // Result offered by the sequencer to the output register
  typedef struct packed {
    logic       valid;
    flip_word_t word;
  } emit_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SPAN,
    ST_BEST0,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT_TOP,
    ST_EMIT_SPAN,
    ST_FLIP_RD,
    ST_FLIP_WLO,
    ST_FLIP_WHI,
    ST_TERM
  } state_t;

endpackage

>>> design/pfs_store.sv
// Stack store: one write port and two registered read ports.
// Depends on pfs_pkg.
module pfs_store (
  input  logic                clk,
  input  pfs_pkg::store_req_t req,
  output pfs_pkg::value_t     rd_a,
  output pfs_pkg::value_t     rd_b
);

  pfs_pkg::value_t mem [pfs_pkg::STACK_DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Register both read ports
  always_ff @(posedge clk) begin
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

>>> design/pfs_ctrl.sv
// Sequencer of the pancake flip sorter: loads the stack, scans each span
// for its largest value with one comparator, and swaps entries for flips.
// Depends on pfs_pkg.
module pfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  pfs_pkg::load_word_t load_word,
  output pfs_pkg::store_req_t req,
  input  pfs_pkg::value_t     rd_a,
  input  pfs_pkg::value_t     rd_b,
  output pfs_pkg::emit_t      emit,
  input  logic                out_free
);

  pfs_pkg::state_t state, state_next;
  pfs_pkg::count_t count;
  pfs_pkg::count_t settled;
  pfs_pkg::addr_t  idx;
  pfs_pkg::addr_t  best;
  pfs_pkg::value_t best_val;
  pfs_pkg::addr_t  lo;
  pfs_pkg::addr_t  hi;
  pfs_pkg::value_t hold_val;
  logic            flip_span;

  pfs_pkg::count_t bottom_cnt;
  pfs_pkg::addr_t  bottom;
  logic            room;
  logic            load_fire;

  assign bottom_cnt = count - settled - pfs_pkg::CNT_W'(1);
  assign bottom     = bottom_cnt[pfs_pkg::ADDR_W-1:0];
  assign room       = count < pfs_pkg::CNT_W'(pfs_pkg::STACK_DEPTH);
  assign load_fire  = (state == pfs_pkg::ST_LOAD) && load_valid;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfs_pkg::ST_LOAD: begin
        if (load_valid && load_word.end_of_stack) state_next = pfs_pkg::ST_SPAN;
      end
      pfs_pkg::ST_SPAN: begin
        if ((settled + pfs_pkg::CNT_W'(1)) >= count) state_next = pfs_pkg::ST_TERM;
        else state_next = pfs_pkg::ST_BEST0;
      end
      pfs_pkg::ST_BEST0: state_next = pfs_pkg::ST_SCAN;
      pfs_pkg::ST_SCAN: begin
        if (idx == bottom) state_next = pfs_pkg::ST_DECIDE;
      end
      pfs_pkg::ST_DECIDE: begin
        if (best == bottom) state_next = pfs_pkg::ST_SPAN;
        else if (best != '0) state_next = pfs_pkg::ST_EMIT_TOP;
        else state_next = pfs_pkg::ST_EMIT_SPAN;
      end
      pfs_pkg::ST_EMIT_TOP, pfs_pkg::ST_EMIT_SPAN: begin
        if (out_free) state_next = pfs_pkg::ST_FLIP_RD;
      end
      pfs_pkg::ST_FLIP_RD: begin
        if (lo >= hi) begin
          state_next = flip_span ? pfs_pkg::ST_SPAN : pfs_pkg::ST_EMIT_SPAN;
        end else begin
          state_next = pfs_pkg::ST_FLIP_WLO;
        end
      end
      pfs_pkg::ST_FLIP_WLO: state_next = pfs_pkg::ST_FLIP_WHI;
      pfs_pkg::ST_FLIP_WHI: state_next = pfs_pkg::ST_FLIP_RD;
      pfs_pkg::ST_TERM: begin
        if (out_free) state_next = pfs_pkg::ST_LOAD;
      end
      default: state_next = pfs_pkg::ST_LOAD;
    endcase
  end

  // Outputs: store request, offered result, load handshake
  always_comb begin
    load_ready   = 1'b0;
    req.we       = 1'b0;
    req.waddr    = lo;
    req.wdata    = rd_b;
    req.raddr_a  = idx;
    req.raddr_b  = hi;
    emit.valid   = 1'b0;
    emit.word.flip_position = '0;
    emit.word.last_flip     = 1'b0;
    unique case (state)
      pfs_pkg::ST_LOAD: begin
        load_ready = 1'b1;
        req.we     = load_valid && room;
        req.waddr  = count[pfs_pkg::ADDR_W-1:0];
        req.wdata  = load_word.diameter;
      end
      pfs_pkg::ST_SPAN: req.raddr_a = bottom;
      pfs_pkg::ST_BEST0: req.raddr_a = idx;
      pfs_pkg::ST_SCAN: req.raddr_a = idx + pfs_pkg::ADDR_W'(1);
      pfs_pkg::ST_DECIDE: ;
      pfs_pkg::ST_EMIT_TOP: begin
        emit.valid = 1'b1;
        emit.word.flip_position =
          pfs_pkg::FLIP_W'(count - pfs_pkg::CNT_W'(best));
      end
      pfs_pkg::ST_EMIT_SPAN: begin
        emit.valid = 1'b1;
        emit.word.flip_position =
          pfs_pkg::FLIP_W'(settled + pfs_pkg::CNT_W'(1));
      end
      pfs_pkg::ST_FLIP_RD: begin
        req.raddr_a = lo;
        req.raddr_b = hi;
      end
      pfs_pkg::ST_FLIP_WLO: begin
        req.we    = 1'b1;
        req.waddr = lo;
        req.wdata = rd_b;
      end
      pfs_pkg::ST_FLIP_WHI: begin
        req.we    = 1'b1;
        req.waddr = hi;
        req.wdata = hold_val;
      end
      pfs_pkg::ST_TERM: begin
        emit.valid          = 1'b1;
        emit.word.last_flip = 1'b1;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfs_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Element count and settled span count
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      settled <= '0;
    end else begin
      if (load_fire && room) begin
        count <= count + pfs_pkg::CNT_W'(1);
      end
      if (state == pfs_pkg::ST_DECIDE && best == bottom) begin
        settled <= settled + pfs_pkg::CNT_W'(1);
      end
      if (state == pfs_pkg::ST_FLIP_RD && lo >= hi && flip_span) begin
        settled <= settled + pfs_pkg::CNT_W'(1);
      end
      if (state == pfs_pkg::ST_TERM && out_free) begin
        count   <= '0;
        settled <= '0;
      end
    end
  end

  // Scan for the largest value and step through the swaps of a flip
  always_ff @(posedge clk) begin
    unique case (state)
      pfs_pkg::ST_SPAN: begin
        idx  <= '0;
        best <= bottom;
      end
      pfs_pkg::ST_BEST0: best_val <= rd_a;
      pfs_pkg::ST_SCAN: begin
        if (best_val < rd_a) begin
          best     <= idx;
          best_val <= rd_a;
        end
        idx <= idx + pfs_pkg::ADDR_W'(1);
      end
      pfs_pkg::ST_EMIT_TOP: begin
        lo        <= '0;
        hi        <= best;
        flip_span <= 1'b0;
      end
      pfs_pkg::ST_EMIT_SPAN: begin
        lo        <= '0;
        hi        <= bottom;
        flip_span <= 1'b1;
      end
      pfs_pkg::ST_FLIP_WLO: hold_val <= rd_a;
      pfs_pkg::ST_FLIP_WHI: begin
        lo <= lo + pfs_pkg::ADDR_W'(1);
        hi <= hi - pfs_pkg::ADDR_W'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> design/pancake_flip_sorter.sv
// Pancake flip sorter: takes one stack word per cycle while loading; after
// the word marked end_of_stack it sorts by prefix reversals and emits each
// flip position, then a 0 marked last. The store is a two-read-port RAM;
// a span scan uses one comparator and a flip swaps each pair by a read, a
// low write and a high write; loading stops until the terminator has been
// passed to the output register. Synchronous reset empties the stack.
module pancake_flip_sorter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  pfs_pkg::load_word_t load_word,
  output logic                flip_valid,
  input  logic                flip_ready,
  output pfs_pkg::flip_word_t flip_word
);

  pfs_pkg::store_req_t req;
  pfs_pkg::value_t     rd_a;
  pfs_pkg::value_t     rd_b;
  pfs_pkg::emit_t      emit;
  logic                out_free;

  assign out_free = !flip_valid || flip_ready;

  pfs_store u_store (
    .clk  (clk),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  pfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load_word  (load_word),
    .req        (req),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .emit       (emit),
    .out_free   (out_free)
  );

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      flip_valid <= 1'b0;
    end else if (out_free) begin
      flip_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      flip_word <= emit.word;
    end
  end

endmodule
